>>> hw/rtl/m4vt_pkg.sv
// ----------------------------------------------------------------------------
// m4vt_pkg
// Shared types, widths and register codes for the 4x4 matrix-vector transform.
// ----------------------------------------------------------------------------
package m4vt_pkg;

  localparam int WORD_W        = 32;
  localparam int NUM_ROWS      = 4;
  localparam int NUM_COLS      = 4;
  localparam int NUM_REGS      = 8;
  localparam int REG_IDX_W     = $clog2(NUM_REGS);
  localparam int CFG_ADDR_W    = 4;
  localparam int CFG_DATA_W    = 64;
  localparam int FRAC_BITS_DEF = 16;
  localparam int NUM_STAGES    = 4;
  localparam int PROD_W        = 2 * WORD_W;
  localparam int PAIR_W        = PROD_W + 1;
  localparam int SUM_W         = PROD_W + 2;

  // Matrix register indexes
  localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS01 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ROW0_COLS23 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS01 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_ROW1_COLS23 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS01 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_ROW2_COLS23 = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS01 = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_ROW3_COLS23 = 3'd7;

  typedef logic signed [WORD_W-1:0] word_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] adv;
  } pipe_ctl_t;

  // Identity matrix: a 1.0 on the diagonal, lower column in the low half
  function automatic logic [CFG_DATA_W-1:0] reg_reset(
    input logic [REG_IDX_W-1:0] idx,
    input int                   frac_bits
  );
    logic [CFG_DATA_W-1:0] one;
    logic [CFG_DATA_W-1:0] val;
    one = CFG_DATA_W'(1) << frac_bits;
    unique case (idx)
      REG_ROW0_COLS01: val = one;
      REG_ROW1_COLS01: val = one << WORD_W;
      REG_ROW2_COLS23: val = one;
      REG_ROW3_COLS23: val = one << WORD_W;
      REG_ROW0_COLS23,
      REG_ROW1_COLS23,
      REG_ROW2_COLS01,
      REG_ROW3_COLS01: val = '0;
      default:         val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> hw/rtl/m4vt_if.sv
// ----------------------------------------------------------------------------
// m4vt channel interfaces
// Vector input, vector result and configuration write channels.
// ----------------------------------------------------------------------------
interface m4vt_vec_in_if;
  logic          valid;
  logic          ready;
  m4vt_pkg::word_t in_x;
  m4vt_pkg::word_t in_y;
  m4vt_pkg::word_t in_z;
  m4vt_pkg::word_t in_w;

  modport source (output valid, output in_x, output in_y, output in_z, output in_w,
                  input ready);
  modport sink   (input valid, input in_x, input in_y, input in_z, input in_w,
                  output ready);
endinterface

interface m4vt_vec_out_if;
  logic          valid;
  logic          ready;
  m4vt_pkg::word_t out_x;
  m4vt_pkg::word_t out_y;
  m4vt_pkg::word_t out_z;
  m4vt_pkg::word_t out_w;

  modport source (output valid, output out_x, output out_y, output out_z, output out_w,
                  input ready);
  modport sink   (input valid, input out_x, input out_y, input out_z, input out_w,
                  output ready);
endinterface

interface m4vt_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [m4vt_pkg::CFG_ADDR_W-1:0]   addr;
  logic [m4vt_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

>>> hw/rtl/m4vt_row_dot.sv
// ----------------------------------------------------------------------------
// m4vt_row_dot
// Datapath for one matrix row: four products, a two-level adder tree, then
// shift by the fraction bits and saturate to 32 bits. Four register stages.
// ----------------------------------------------------------------------------
module m4vt_row_dot #(
  parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  m4vt_pkg::pipe_ctl_t   ctl,
  input  m4vt_pkg::word_t       coef [m4vt_pkg::NUM_COLS],
  input  m4vt_pkg::word_t       vec  [m4vt_pkg::NUM_COLS],
  output m4vt_pkg::word_t       res
);

  localparam int WORD_W = m4vt_pkg::WORD_W;
  localparam int SUM_W  = m4vt_pkg::SUM_W;
  localparam int HI_W   = SUM_W - WORD_W + 1;

  logic signed [m4vt_pkg::PROD_W-1:0] prod [m4vt_pkg::NUM_COLS];
  logic signed [m4vt_pkg::PAIR_W-1:0] pair [2];
  logic signed [SUM_W-1:0]            sum;
  logic signed [SUM_W-1:0]            shifted;
  logic        [HI_W-1:0]             hi;
  m4vt_pkg::word_t                    res_next;

  // Stage 0: products
  always_ff @(posedge clk) begin
    if (ctl.adv[0]) begin
      for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
        prod[c] <= coef[c] * vec[c];
      end
    end
  end

  // Stage 1: pair sums
  always_ff @(posedge clk) begin
    if (ctl.adv[1]) begin
      pair[0] <= prod[0] + prod[1];
      pair[1] <= prod[2] + prod[3];
    end
  end

  // Stage 2: full sum
  always_ff @(posedge clk) begin
    if (ctl.adv[2]) begin
      sum <= pair[0] + pair[1];
    end
  end

  // Stage 3: floor shift, then clamp when the upper bits are not all sign
  always_comb begin
    shifted = sum >>> FRAC_BITS;
    hi      = shifted[SUM_W-1:WORD_W-1];
    if ((&hi) || !(|hi)) begin
      res_next = shifted[WORD_W-1:0];
    end else if (shifted[SUM_W-1]) begin
      res_next = {1'b1, {(WORD_W-1){1'b0}}};
    end else begin
      res_next = {1'b0, {(WORD_W-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv[3]) begin
      res <= res_next;
    end
  end

endmodule

>>> hw/rtl/matrix4_vector_transform.sv
// ----------------------------------------------------------------------------
// matrix4_vector_transform
// Multiplies each input vector by a configurable 4x4 Q-format matrix.
//
//   port     dir    beat payload
//   vertex   sink   in_x, in_y, in_z, in_w (signed, 32 bits each)
//   result   source out_x, out_y, out_z, out_w (signed, 32 bits, saturated)
//   cfg      sink   addr (register index), data (two packed entries)
//
// Four-stage pipeline (multiply, pair add, final add, shift and clamp); one
// beat per cycle in, one per cycle out, while the result channel is not stalled.
// Reset loads the identity matrix and empties the pipeline.
// Each stage advances when it is empty or the next stage advances, so bubbles
// fill during a result stall; cfg is always ready, indexes above 7 are dropped.
// ----------------------------------------------------------------------------
module matrix4_vector_transform #(
  parameter int FRAC_BITS = m4vt_pkg::FRAC_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  m4vt_vec_in_if.sink     vertex,
  m4vt_vec_out_if.source  result,
  m4vt_cfg_if.sink        cfg
);

  localparam int NUM_STAGES = m4vt_pkg::NUM_STAGES;
  localparam int WORD_W     = m4vt_pkg::WORD_W;

  logic [m4vt_pkg::CFG_DATA_W-1:0] mat [m4vt_pkg::NUM_REGS];
  m4vt_pkg::word_t                 coef [m4vt_pkg::NUM_ROWS][m4vt_pkg::NUM_COLS];
  m4vt_pkg::word_t                 vec  [m4vt_pkg::NUM_COLS];
  m4vt_pkg::word_t                 res  [m4vt_pkg::NUM_ROWS];
  logic [NUM_STAGES-1:0]           stage_v;
  m4vt_pkg::pipe_ctl_t             ctl;

  // Matrix registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < m4vt_pkg::NUM_REGS; i++) begin
        mat[i] <= m4vt_pkg::reg_reset(m4vt_pkg::REG_IDX_W'(i), FRAC_BITS);
      end
    end else if (cfg.valid && cfg.ready &&
                 (cfg.addr < m4vt_pkg::CFG_ADDR_W'(m4vt_pkg::NUM_REGS))) begin
      mat[cfg.addr[m4vt_pkg::REG_IDX_W-1:0]] <= cfg.data;
    end
  end

  always_comb begin
    for (int r = 0; r < m4vt_pkg::NUM_ROWS; r++) begin
      for (int c = 0; c < m4vt_pkg::NUM_COLS; c++) begin
        coef[r][c] = mat[r * 2 + c / 2][(c % 2) * WORD_W +: WORD_W];
      end
    end
  end

  assign vec[0] = vertex.in_x;
  assign vec[1] = vertex.in_y;
  assign vec[2] = vertex.in_z;
  assign vec[3] = vertex.in_w;

  // Stage control: a stage advances when empty or when its successor advances
  always_comb begin
    ctl.adv[NUM_STAGES-1] = !stage_v[NUM_STAGES-1] || result.ready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctl.adv[i] = !stage_v[i] || ctl.adv[i+1];
    end
  end

  assign vertex.ready = ctl.adv[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
    end else begin
      if (ctl.adv[0]) begin
        stage_v[0] <= vertex.valid;
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ctl.adv[i]) begin
          stage_v[i] <= stage_v[i-1];
        end
      end
    end
  end

  for (genvar r = 0; r < m4vt_pkg::NUM_ROWS; r++) begin : g_row
    m4vt_row_dot #(
      .FRAC_BITS (FRAC_BITS)
    ) u_row (
      .clk  (clk),
      .ctl  (ctl),
      .coef (coef[r]),
      .vec  (vec),
      .res  (res[r])
    );
  end

  assign result.valid = stage_v[NUM_STAGES-1];
  assign result.out_x = res[0];
  assign result.out_y = res[1];
  assign result.out_z = res[2];
  assign result.out_w = res[3];

  // Reset empties every stage
  a_rst_empty: assert property (@(posedge clk) rst |=> (stage_v == '0))
    else $error("pipeline not empty after reset");

  // An accepted beat lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (vertex.valid && vertex.ready) |=> stage_v[0])
    else $error("accepted beat lost at stage 0");

  // A full stage that cannot advance keeps its item
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_v[1] && !ctl.adv[1]) |=> stage_v[1])
    else $error("stalled item dropped at stage 1");

  // A result taken with nothing behind it leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.ready && !stage_v[NUM_STAGES-2]) |=> !result.valid)
    else $error("result repeated after drain");

endmodule
